[sv/dfrc_pkg.sv]
// Package for the fractional-rate DSSS chip generator.
// Holds the request and response payload types, config struct and sizes.
// No dependencies.
package dfrc_pkg;

   localparam int CODE_DEPTH = 1024;
   localparam int DATA_DEPTH = 1024;
   localparam int RATE_WIDTH = 16;
   localparam int LEN_WIDTH  = 11;
   localparam int IDX_WIDTH  = 10;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   typedef enum logic [1:0] {
      ACT_LOAD_CODE = 2'd0,
      ACT_LOAD_DATA = 2'd1,
      ACT_EMIT      = 2'd2,
      ACT_RESTART   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_CODE_LENGTH = 2'd0,
      REG_DATA_LENGTH = 2'd1,
      REG_RATE_NUM    = 2'd2,
      REG_RATE_DEN    = 2'd3
   } reg_index_type;

   typedef struct packed {
      action_type           action;
      logic [IDX_WIDTH-1:0] slot;
      logic                 bit_value;
   } req_type;

   typedef struct packed {
      logic                 chip;
      logic [IDX_WIDTH-1:0] code_phase;
      logic [IDX_WIDTH-1:0] symbol_slot;
   } rsp_type;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]  code_length;
      logic [LEN_WIDTH-1:0]  data_length;
      logic [RATE_WIDTH-1:0] rate_numerator;
      logic [RATE_WIDTH-1:0] rate_denominator;
   } cfg_type;

   // Sequencer controls from the request side
   typedef struct packed {
      logic step;
      logic restart;
   } seq_ctrl_type;

   // Clamp a length register to 1..depth
   function automatic logic [LEN_WIDTH-1:0] eff_len(input logic [LEN_WIDTH-1:0] len,
                                                    input logic [LEN_WIDTH-1:0] depth);
      logic [LEN_WIDTH-1:0] r;
      if (len == '0) r = LEN_WIDTH'(1);
      else if (len > depth) r = depth;
      else r = len;
      return r;
   endfunction

endpackage

[sv/dsss_fractional_rate_chip_generator_core.sv]
// Top level of the fractional-rate DSSS chip generator.
// Depends on dfrc_pkg, dfrc_csr, dfrc_seq, dfrc_bit_ram.
//
//   channel | direction | payload           | handshake
//   req_    | in        | dfrc_pkg::req_type | req_valid / req_ready
//   rsp_    | out       | dfrc_pkg::rsp_type | rsp_valid / rsp_ready
//   csr_    | in/out    | 32-bit registers   | psel / penable, pready high
//
// One request per clock while req_ready is high. An emit request's accepting edge
// loads the code and data store reads; the response register, raising rsp_valid,
// loads when the read stage advances. Loads and restarts give no response.
// Reset (synchronous) clears indices, accumulator and valids; the bit stores
// hold nothing until written. A stalled response holds the read stage, then req_ready.
module dsss_fractional_rate_chip_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dfrc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dfrc_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dfrc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dfrc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dfrc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int IW = dfrc_pkg::IDX_WIDTH;

   dfrc_pkg::cfg_type      cfg;
   dfrc_pkg::seq_ctrl_type seq_ctrl;
   logic [IW-1:0]          code_addr, data_addr;
   logic                   code_bit, data_bit;

   logic                   req_fire, emit_fire;
   logic                   code_we, data_we;
   logic                   s1_adv;

   logic                   s1_valid_ff, s1_valid_in;
   logic [IW-1:0]          s1_code_phase_ff, s1_symbol_slot_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dfrc_pkg::rsp_type      rsp_data_ff;

   dfrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = req_fire && (req_data.action == dfrc_pkg::ACT_EMIT);

   assign code_we = req_fire && (req_data.action == dfrc_pkg::ACT_LOAD_CODE)
                    && (32'(req_data.slot) < 32'(dfrc_pkg::CODE_DEPTH));
   assign data_we = req_fire && (req_data.action == dfrc_pkg::ACT_LOAD_DATA)
                    && (32'(req_data.slot) < 32'(dfrc_pkg::DATA_DEPTH));

   assign seq_ctrl.step    = emit_fire;
   assign seq_ctrl.restart = req_fire && (req_data.action == dfrc_pkg::ACT_RESTART);

   dfrc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (seq_ctrl),
      .code_addr (code_addr),
      .data_addr (data_addr)
   );

   dfrc_bit_ram #(.DEPTH(dfrc_pkg::CODE_DEPTH), .AW(IW)) u_code_ram (
      .clock    (clock),
      .we       (code_we),
      .waddr    (req_data.slot),
      .wdata    (req_data.bit_value),
      .re       (emit_fire),
      .raddr    (code_addr),
      .rdata_ff (code_bit)
   );

   dfrc_bit_ram #(.DEPTH(dfrc_pkg::DATA_DEPTH), .AW(IW)) u_data_ram (
      .clock    (clock),
      .we       (data_we),
      .waddr    (req_data.slot),
      .wdata    (req_data.bit_value),
      .re       (emit_fire),
      .raddr    (data_addr),
      .rdata_ff (data_bit)
   );

   always_comb begin
      if (emit_fire) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;

      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: read stage indices and response register
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         s1_code_phase_ff  <= code_addr;
         s1_symbol_slot_ff <= data_addr;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff.chip        <= code_bit ^ data_bit;
         rsp_data_ff.code_phase  <= s1_code_phase_ff;
         rsp_data_ff.symbol_slot <= s1_symbol_slot_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ready)
      else $error("request taken while read stage is blocked");

   assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> s1_valid_ff)
      else $error("emit request lost before read stage");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && !emit_fire && !s1_valid_ff |=> !s1_valid_ff)
      else $error("load or restart produced a chip");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_adv |=> rsp_valid_ff)
      else $error("read stage item dropped on way to response");

endmodule

[sv/dfrc_bit_ram.sv]
// One-bit wide single-write, single-read RAM with registered read data.
// No dependencies.
module dfrc_bit_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic          wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic          rdata_ff
);

   logic mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

[sv/dfrc_csr.sv]
// Configuration registers behind the APB-style port, with read-back.
// Depends on dfrc_pkg.
module dfrc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dfrc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dfrc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dfrc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output dfrc_pkg::cfg_type             cfg
);

   dfrc_pkg::cfg_type       cfg_ff, cfg_in;
   dfrc_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = dfrc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            dfrc_pkg::REG_CODE_LENGTH: begin
               cfg_in.code_length = csr_pwdata[dfrc_pkg::LEN_WIDTH-1:0];
            end
            dfrc_pkg::REG_DATA_LENGTH: begin
               cfg_in.data_length = csr_pwdata[dfrc_pkg::LEN_WIDTH-1:0];
            end
            dfrc_pkg::REG_RATE_NUM: begin
               cfg_in.rate_numerator = csr_pwdata[dfrc_pkg::RATE_WIDTH-1:0];
            end
            dfrc_pkg::REG_RATE_DEN: begin
               cfg_in.rate_denominator = csr_pwdata[dfrc_pkg::RATE_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_length      <= dfrc_pkg::LEN_WIDTH'(1);
         cfg_ff.data_length      <= dfrc_pkg::LEN_WIDTH'(1);
         cfg_ff.rate_numerator   <= dfrc_pkg::RATE_WIDTH'(1);
         cfg_ff.rate_denominator <= dfrc_pkg::RATE_WIDTH'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         dfrc_pkg::REG_CODE_LENGTH: csr_prdata = dfrc_pkg::CSR_DW'(cfg_ff.code_length);
         dfrc_pkg::REG_DATA_LENGTH: csr_prdata = dfrc_pkg::CSR_DW'(cfg_ff.data_length);
         dfrc_pkg::REG_RATE_NUM:    csr_prdata = dfrc_pkg::CSR_DW'(cfg_ff.rate_numerator);
         dfrc_pkg::REG_RATE_DEN:    csr_prdata = dfrc_pkg::CSR_DW'(cfg_ff.rate_denominator);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[sv/dfrc_seq.sv]
// Code index, data index and rational rate accumulator.
// Presents the indices for the current chip; steps them on each emit (data index at the set rate); restart clears them.
// Depends on dfrc_pkg.
module dfrc_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  dfrc_pkg::cfg_type                 cfg,
   input  dfrc_pkg::seq_ctrl_type            ctrl,
   output logic [dfrc_pkg::IDX_WIDTH-1:0]    code_addr,
   output logic [dfrc_pkg::IDX_WIDTH-1:0]    data_addr
);

   localparam int LW = dfrc_pkg::LEN_WIDTH;
   localparam int RW = dfrc_pkg::RATE_WIDTH;
   localparam int IW = dfrc_pkg::IDX_WIDTH;

   logic [IW-1:0] code_index_ff, code_index_in;
   logic [IW-1:0] data_index_ff, data_index_in;
   logic [RW-1:0] acc_ff, acc_in;

   logic [LW-1:0] clen, dlen;
   logic [RW-1:0] num, den_raw, den;
   logic [LW-1:0] code_inc, data_inc;
   logic [RW:0]   acc_sum;
   logic          sym_step;

   always_comb begin
      clen    = dfrc_pkg::eff_len(cfg.code_length, LW'(dfrc_pkg::CODE_DEPTH));
      dlen    = dfrc_pkg::eff_len(cfg.data_length, LW'(dfrc_pkg::DATA_DEPTH));
      num     = (cfg.rate_numerator == '0) ? RW'(1) : cfg.rate_numerator;
      den_raw = (cfg.rate_denominator == '0) ? RW'(1) : cfg.rate_denominator;
      den     = (den_raw > num) ? num : den_raw;

      // a lowered length sends a stale index back to zero
      code_addr = (LW'(code_index_ff) >= clen) ? '0 : code_index_ff;
      data_addr = (LW'(data_index_ff) >= dlen) ? '0 : data_index_ff;

      code_inc = LW'(code_addr) + LW'(1);
      data_inc = LW'(data_addr) + LW'(1);

      // acc stays below 2^RW: the one subtraction never leaves it above its old value
      acc_sum  = (RW+1)'(acc_ff) + (RW+1)'(den);
      sym_step = acc_sum >= (RW+1)'(num);

      code_index_in = code_index_ff;
      data_index_in = data_index_ff;
      acc_in        = acc_ff;
      priority if (ctrl.restart) begin
         code_index_in = '0;
         data_index_in = '0;
         acc_in        = '0;
      end else if (ctrl.step) begin
         code_index_in = (code_inc >= clen) ? '0 : code_inc[IW-1:0];
         if (sym_step) begin
            acc_in        = RW'(acc_sum - (RW+1)'(num));
            data_index_in = (data_inc >= dlen) ? '0 : data_inc[IW-1:0];
         end else begin
            acc_in        = acc_sum[RW-1:0];
            data_index_in = data_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_index_ff <= '0;
         data_index_ff <= '0;
         acc_ff        <= '0;
      end else begin
         code_index_ff <= code_index_in;
         data_index_ff <= data_index_in;
         acc_ff        <= acc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.step && !ctrl.restart |=> code_index_ff < IW'(dfrc_pkg::CODE_DEPTH - 1)
                                     || code_index_ff == IW'(dfrc_pkg::CODE_DEPTH - 1)
                                     || code_index_ff == '0)
      else $error("code index out of range after step");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.step && !ctrl.restart && (LW'(code_index_ff) + LW'(1) < clen)
         && (LW'(code_index_ff) < clen)
      |=> code_index_ff == $past(code_index_ff) + IW'(1))
      else $error("code index did not advance by one");

   assert property (@(posedge clock) disable iff (reset)
      !ctrl.step && !ctrl.restart |=> $stable(acc_ff) && $stable(data_index_ff))
      else $error("rate state moved without a chip");

endmodule
